@@ sv/cce_pkg.sv @@
// Shared types, codes and helpers for the CIGAR check and =/X rewrite unit.
// Used by every module under sv/; depends on nothing else.
`default_nettype none

package cce_pkg;

    // CIGAR operation codes (input opcode and output cigar_op)
    localparam logic [3:0] OP_M  = 4'd0;
    localparam logic [3:0] OP_I  = 4'd1;
    localparam logic [3:0] OP_D  = 4'd2;
    localparam logic [3:0] OP_N  = 4'd3;
    localparam logic [3:0] OP_S  = 4'd4;
    localparam logic [3:0] OP_H  = 4'd5;
    localparam logic [3:0] OP_P  = 4'd6;
    localparam logic [3:0] OP_EQ = 4'd7;
    localparam logic [3:0] OP_X  = 4'd8;

    // Result kinds
    localparam logic [1:0] KIND_BASE    = 2'd0;
    localparam logic [1:0] KIND_CIGAR   = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // Verdict codes
    localparam logic [2:0] VD_OK        = 3'd0;
    localparam logic [2:0] VD_QLEN      = 3'd1;
    localparam logic [2:0] VD_BAD_REF   = 3'd2;
    localparam logic [2:0] VD_REF_RANGE = 3'd3;
    localparam logic [2:0] VD_QRY_RANGE = 3'd4;
    localparam logic [2:0] VD_EQ_MISM   = 3'd5;
    localparam logic [2:0] VD_X_MATCH   = 3'd6;

    // Limits
    localparam logic [16:0] MAX_READ_LEN = 17'd65535;
    localparam logic [16:0] MAX_REFS     = 17'd65536;
    localparam logic [27:0] RUN_MAX      = 28'hFFF_FFFF;
    localparam logic [16:0] QPOS_MAX     = 17'h1_FFFF;
    localparam logic signed [32:0] RPOS_MAX = 33'sh0_FFFF_FFFF;
    localparam logic [7:0]  CHAR_EQ      = 8'h3D;

    // Bus widths and result slots per item
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 48;
    localparam int SLOTS       = 4;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [7:0]         ref_base;
        logic [7:0]         read_base;
        logic               end_of_element;
        logic               first_of_record;
        logic               last_of_record;
        logic               unmapped;
        logic signed [16:0] reference_id;
        logic signed [31:0] start_position;
        logic [30:0]        reference_length;
        logic [15:0]        read_length;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_base;
        logic [3:0]  cigar_op;
        logic [27:0] cigar_length;
        logic [2:0]  verdict;
        logic        last;
    } result_t;

    // All results caused by one item, packed from slot 0 up
    typedef struct packed {
        result_t [SLOTS-1:0] slot;
        logic [2:0]          count;
    } bundle_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        upcase = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

endpackage

`default_nettype wire

@@ sv/cce_in_stage.sv @@
// Input register of the CIGAR check unit: unpacks the slave stream into an item.
// Depends on cce_pkg.
`default_nettype none

module cce_in_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [cce_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           s_tlast,
    input  wire logic                           advance,
    output logic                                item_valid,
    output cce_pkg::item_t                      item
);

    logic           valid_reg;
    logic           valid_next;
    cce_pkg::item_t item_reg;
    cce_pkg::item_t item_next;
    logic           take;

    assign s_tready   = !valid_reg || advance;
    assign take       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Unpack the bus fields
    always_comb begin
        item_next.opcode           = s_tdata[3:0];
        item_next.ref_base         = s_tdata[11:4];
        item_next.read_base        = s_tdata[19:12];
        item_next.end_of_element   = s_tdata[20];
        item_next.reference_id     = s_tdata[37:21];
        item_next.start_position   = s_tdata[69:38];
        item_next.reference_length = s_tdata[100:70];
        item_next.read_length      = s_tdata[116:101];
        item_next.first_of_record  = s_tuser[0];
        item_next.unmapped         = s_tuser[1];
        item_next.last_of_record   = s_tlast;
    end

    // Hold the item until the core takes it
    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/cce_core.sv @@
// Record state, checks and =/X run tracking; builds the results of one item.
// Depends on cce_pkg.
`default_nettype none

module cce_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [16:0]      cfg_wdata,
    input  wire logic             advance,
    input  wire cce_pkg::item_t   item,
    output cce_pkg::bundle_t      bundle
);

    logic [16:0]        refcnt_reg;
    logic signed [32:0] rpos_reg, rpos_next;
    logic [16:0]        qpos_reg, qpos_next;
    logic [3:0]         rop_reg, rop_next;
    logic [27:0]        rlen_reg, rlen_next;
    logic [2:0]         err_reg, err_next;
    logic [30:0]        reflen_reg, reflen_next;
    logic [15:0]        rdlen_reg, rdlen_next;

    // Effective state at the item, after a record start if any
    logic signed [32:0] rp_eff;
    logic [16:0]        qp_eff;
    logic [3:0]         rop_eff;
    logic [27:0]        rl_eff;
    logic [2:0]         err_eff;
    logic [30:0]        reflen_eff;
    logic [15:0]        rdlen_eff;
    logic [16:0]        rc_eff;

    logic        cref, cqry, op_ok, same, flush, end_run;
    logic [2:0]  chk, err_new, vd;
    logic [3:0]  sub;
    logic [3:0]  rop_b;
    logic [27:0] rl_a, rl_b;
    logic signed [32:0] rp_new;
    logic [16:0] qp_new;

    cce_pkg::result_t [cce_pkg::SLOTS-1:0] cand;
    logic [cce_pkg::SLOTS-1:0]             cand_en;
    logic [2:0]                            cnt;

    // Record start: fresh positions, limits and header checks
    always_comb begin
        rc_eff = (refcnt_reg > cce_pkg::MAX_REFS) ? cce_pkg::MAX_REFS : refcnt_reg;
        if (item.first_of_record) begin
            rp_eff     = {item.start_position[31], item.start_position};
            qp_eff     = '0;
            rop_eff    = cce_pkg::OP_M;
            rl_eff     = '0;
            reflen_eff = item.reference_length;
            rdlen_eff  = item.read_length;
            if (item.reference_id[16] || {1'b0, item.reference_id[15:0]} >= rc_eff) begin
                err_eff = cce_pkg::VD_BAD_REF;
            end else if ({1'b0, item.read_length} > cce_pkg::MAX_READ_LEN) begin
                err_eff = cce_pkg::VD_QRY_RANGE;
            end else begin
                err_eff = cce_pkg::VD_OK;
            end
        end else begin
            rp_eff     = rpos_reg;
            qp_eff     = qpos_reg;
            rop_eff    = rop_reg;
            rl_eff     = rlen_reg;
            err_eff    = err_reg;
            reflen_eff = reflen_reg;
            rdlen_eff  = rdlen_reg;
        end
    end

    // Per-step checks and run tracking
    always_comb begin
        cref = item.opcode == cce_pkg::OP_M || item.opcode == cce_pkg::OP_D
            || item.opcode == cce_pkg::OP_N || item.opcode == cce_pkg::OP_EQ
            || item.opcode == cce_pkg::OP_X;
        cqry = item.opcode == cce_pkg::OP_M || item.opcode == cce_pkg::OP_I
            || item.opcode == cce_pkg::OP_S || item.opcode == cce_pkg::OP_EQ
            || item.opcode == cce_pkg::OP_X;
        op_ok = item.opcode <= cce_pkg::OP_X;
        same  = cce_pkg::upcase(item.ref_base) == cce_pkg::upcase(item.read_base);

        if (cref && (rp_eff[32] || rp_eff >= $signed({2'b00, reflen_eff}))) begin
            chk = cce_pkg::VD_REF_RANGE;
        end else if (cqry && qp_eff >= {1'b0, rdlen_eff}) begin
            chk = cce_pkg::VD_QRY_RANGE;
        end else if (item.opcode == cce_pkg::OP_EQ && !same) begin
            chk = cce_pkg::VD_EQ_MISM;
        end else if (item.opcode == cce_pkg::OP_X && same) begin
            chk = cce_pkg::VD_X_MATCH;
        end else begin
            chk = cce_pkg::VD_OK;
        end
        err_new = (err_eff == cce_pkg::VD_OK) ? chk : err_eff;

        sub   = (item.opcode == cce_pkg::OP_M) ? (same ? cce_pkg::OP_EQ : cce_pkg::OP_X)
                                               : item.opcode;
        flush = op_ok && rl_eff != '0 && rop_eff != sub;
        rl_a  = flush ? '0 : rl_eff;
        if (op_ok) begin
            rop_b = sub;
            rl_b  = (rl_a < cce_pkg::RUN_MAX) ? rl_a + 28'd1 : rl_a;
        end else begin
            rop_b = rop_eff;
            rl_b  = rl_a;
        end

        rp_new  = (cref && rp_eff != cce_pkg::RPOS_MAX) ? rp_eff + 33'sd1 : rp_eff;
        qp_new  = (cqry && qp_eff != cce_pkg::QPOS_MAX) ? qp_eff + 17'd1 : qp_eff;
        end_run = (item.end_of_element || item.last_of_record) && rl_b != '0;
        vd      = (qp_new != {1'b0, rdlen_eff}) ? cce_pkg::VD_QLEN : err_new;
    end

    // Candidate results in emission order
    always_comb begin
        cand = '0;
        cand[0].kind         = cce_pkg::KIND_CIGAR;
        cand[0].cigar_op     = rop_eff;
        cand[0].cigar_length = rl_eff;
        cand[1].kind         = cce_pkg::KIND_BASE;
        cand[1].out_base     = (sub == cce_pkg::OP_EQ) ? cce_pkg::CHAR_EQ : item.read_base;
        cand[2].kind         = cce_pkg::KIND_CIGAR;
        cand[2].cigar_op     = rop_b;
        cand[2].cigar_length = rl_b;
        cand[3].kind         = cce_pkg::KIND_VERDICT;
        cand[3].verdict      = item.unmapped ? cce_pkg::VD_OK : vd;
        cand[3].last         = 1'b1;
        if (item.unmapped) begin
            cand_en = 4'b1000;
        end else begin
            cand_en = {item.last_of_record, end_run, cqry, flush};
        end
    end

    // Pack enabled results from slot 0 up
    always_comb begin
        bundle.slot = '0;
        cnt         = '0;
        for (int i = 0; i < cce_pkg::SLOTS; i++) begin
            if (cand_en[i]) begin
                bundle.slot[cnt[1:0]] = cand[i];
                cnt = cnt + 3'd1;
            end
        end
        bundle.count = cnt;
    end

    // Next record state
    always_comb begin
        rpos_next   = rpos_reg;
        qpos_next   = qpos_reg;
        rop_next    = rop_reg;
        rlen_next   = rlen_reg;
        err_next    = err_reg;
        reflen_next = reflen_reg;
        rdlen_next  = rdlen_reg;
        if (advance) begin
            if (item.unmapped || item.last_of_record) begin
                rpos_next = '0;
                qpos_next = '0;
                rop_next  = cce_pkg::OP_M;
                rlen_next = '0;
                err_next  = cce_pkg::VD_OK;
            end else begin
                rpos_next = rp_new;
                qpos_next = qp_new;
                rop_next  = rop_b;
                rlen_next = end_run ? '0 : rl_b;
                err_next  = err_new;
            end
            if (!item.unmapped) begin
                reflen_next = reflen_eff;
                rdlen_next  = rdlen_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refcnt_reg <= '0;
            rpos_reg   <= '0;
            qpos_reg   <= '0;
            rop_reg    <= cce_pkg::OP_M;
            rlen_reg   <= '0;
            err_reg    <= cce_pkg::VD_OK;
            reflen_reg <= '0;
            rdlen_reg  <= '0;
        end else begin
            if (cfg_we) begin
                refcnt_reg <= cfg_wdata;
            end
            rpos_reg   <= rpos_next;
            qpos_reg   <= qpos_next;
            rop_reg    <= rop_next;
            rlen_reg   <= rlen_next;
            err_reg    <= err_next;
            reflen_reg <= reflen_next;
            rdlen_reg  <= rdlen_next;
        end
    end

    // A run is never left pending past the end of a record
    a_run_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.last_of_record |=> rlen_reg == '0 && qpos_reg == '0)
        else $error("run or position not cleared after record end");

    // An error once latched survives until the record ends
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !item.first_of_record && !item.last_of_record && !item.unmapped
        && err_reg != cce_pkg::VD_OK |=> err_reg == $past(err_reg))
        else $error("latched error overwritten");

    // Run length stays non-zero while a run op is tracked mid-record
    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !item.unmapped && item.opcode <= cce_pkg::OP_X
        && !item.end_of_element && !item.last_of_record |=> rlen_reg != '0)
        else $error("run length lost after a step");

endmodule

`default_nettype wire

@@ sv/cce_out_ser.sv @@
// Result register of the CIGAR check unit: holds one item's results and sends
// them one per beat on the master stream. Depends on cce_pkg.
`default_nettype none

module cce_out_ser (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            load,
    input  wire cce_pkg::bundle_t                bundle,
    output logic                                 free,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [cce_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);

    cce_pkg::bundle_t bundle_reg;
    logic [2:0]       cnt_reg, cnt_next;
    logic [1:0]       idx_reg, idx_next;
    cce_pkg::result_t cur;
    logic             pop;
    logic             last_slot;

    assign cur       = bundle_reg.slot[idx_reg];
    assign m_tvalid  = cnt_reg != '0;
    assign pop       = m_tvalid && m_tready;
    assign last_slot = {1'b0, idx_reg} == cnt_reg - 3'd1;
    assign free      = cnt_reg == '0 || (pop && last_slot);

    // Pack the current result onto the bus
    assign m_tdata = {5'b0, cur.verdict, cur.cigar_length, cur.cigar_op, cur.out_base};
    assign m_tuser = cur.kind;
    assign m_tlast = cur.last;

    // Load a new set of results or advance through the held one
    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = bundle.count;
            idx_next = '0;
        end else if (pop) begin
            if (last_slot) begin
                cnt_next = '0;
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bundle_reg <= bundle;
        end
    end

    // Never overwrite results still waiting to go out
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("results loaded over pending ones");

    // The read index stays inside the held set
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 |-> {1'b0, idx_reg} < cnt_reg && cnt_reg <= 3'd4)
        else $error("result index out of range");

    // Sending the final result without a reload leaves the channel empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && last_slot && !load |=> !m_tvalid)
        else $error("channel not empty after final result");

endmodule

`default_nettype wire

@@ sv/cigar_check_and_eqx_rewrite_unit.sv @@
// Top level of the CIGAR check and =/X rewrite unit.
// Instantiates cce_in_stage, cce_core and cce_out_ser; depends on cce_pkg.
//
//  Channel  | Dir | Handshake          | Content
//  ---------+-----+--------------------+-------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | one CIGAR base step of a record
//  m_       | out | m_tvalid/m_tready  | rewritten base, CIGAR element or verdict
//  cfg_     | in  | cfg_we             | reference_count register
//
//  An item passes the input register and then the result register before its
//  first result goes out. The master side sends one result per beat, so an item
//  with k results (k is 0 to 4) holds the result register until all k are sent;
//  items with at most one result flow at one item per cycle while m_ is not stalled.
//  Reset (aresetn low, synchronous) clears record state, limits and the valid
//  state of both registers. A stall on m_ backs up through both registers to s_tready.
`default_nettype none

module cigar_check_and_eqx_rewrite_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [16:0]                     cfg_wdata,
    // input item stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // opcode[3:0], ref_base[11:4], read_base[19:12], end_of_element[20],
    // reference_id[37:21], start_position[69:38], reference_length[100:70],
    // read_length[116:101], zero[119:117]
    input  wire logic [cce_pkg::IN_TDATA_W-1:0]  s_tdata,
    // first_of_record[0], unmapped[1]
    input  wire logic [1:0]                      s_tuser,
    // last_of_record
    input  wire logic                            s_tlast,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_base[7:0], cigar_op[11:8], cigar_length[39:12], verdict[42:40],
    // zero[47:43]
    output logic [cce_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // kind[1:0]
    output logic [1:0]                           m_tuser,
    // last
    output logic                                 m_tlast
);

    logic             item_valid;
    cce_pkg::item_t   item;
    cce_pkg::bundle_t bundle;
    logic             free;
    logic             advance;
    logic             load;

    // Move an item into the result register when it is free
    assign advance = item_valid && free;
    assign load    = advance && bundle.count != '0;

    cce_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cce_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .bundle    (bundle)
    );

    cce_out_ser u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .bundle   (bundle),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
